### rtl/ssfl_pkg.sv
// Shared types and constants for the slab slot free-list allocator.
// No dependencies; every other file but ssfl_ram refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ssfl_pkg;

    localparam int ADDR_W    = 48;
    localparam int SIZE_W    = 16;
    localparam int CNT_W     = 10;
    localparam int STAT_W    = 2;
    localparam int OCC_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL         = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_IN_SLAB  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTHING_USED = 2'd3;

    localparam logic [OCC_W-1:0] OCC_EMPTY   = 2'd0;
    localparam logic [OCC_W-1:0] OCC_PARTIAL = 2'd1;
    localparam logic [OCC_W-1:0] OCC_FULL    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    localparam logic [ADDR_W-1:0] BASE_RST  = 48'd0;
    localparam logic [SIZE_W-1:0] SIZE_RST  = 16'd16;
    localparam logic [CNT_W-1:0]  COUNT_RST = 10'd256;
    localparam logic [CNT_W-1:0]  COUNT_MAX = 10'd1023;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_WAIT,
        S_FREE_CHK,
        S_FREE_RNG,
        S_FREE_DIV,
        S_FREE_END,
        S_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic clr_wr;
        logic alloc_rd;
        logic alloc_link;
        logic free_sub;
        logic free_rng;
        logic div_step;
        logic free_end;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic head_oor;
        logic rng_fail;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

### rtl/ssfl_ifs.sv
// Channel interfaces: request, result and configuration write.
// Depends on ssfl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ssfl_req_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [ssfl_pkg::ADDR_W-1:0] free_address;

    modport source (output valid, op, free_address, input ready);
    modport sink   (input valid, op, free_address, output ready);
endinterface

interface ssfl_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ssfl_pkg::ADDR_W-1:0] object_address;
    logic [ssfl_pkg::STAT_W-1:0] status;
    logic [ssfl_pkg::CNT_W-1:0]  in_use_count;
    logic [ssfl_pkg::OCC_W-1:0]  occupancy;

    modport source (output valid, object_address, status, in_use_count, occupancy,
                    input ready);
    modport sink   (input valid, object_address, status, in_use_count, occupancy,
                    output ready);
endinterface

interface ssfl_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ssfl_pkg::CFG_IDX_W-1:0] index;
    logic [ssfl_pkg::ADDR_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/slab_slot_free_list_allocator.sv
// Top level of the slab slot free-list allocator: controller plus datapath.
// Depends on ssfl_pkg, ssfl_ifs, ssfl_ctrl and ssfl_dp.
//
// Use: a request beat on i_req carries op (allocate or free) and free_address.
// Each request gives exactly one result beat on o_rsp: object_address, status,
// in_use_count and occupancy. Register writes on i_cfg (index 0 base address,
// 1 object size, 2 object count) are always taken; issue them while idle.
// One request is in flight at a time: a request beat is taken only after the
// result of the last one has been written to the output register. A free
// recovers the slot index with the one-bit-per-cycle restoring divider of
// W = clog2(SLOTS + 1) quotient bits (W = 10 at SLOTS = 512).
// After reset a clearing pass over every slot loads the link RAM, with
// i_req.ready low. A result waiting on a stalled o_rsp holds in its output
// register; the next request is still taken and its result waits for the
// output register to drain before the free list is updated.
`timescale 1ns / 1ps
`default_nettype none

module slab_slot_free_list_allocator #(
    parameter int SLOTS = 512
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ssfl_req_if.sink   i_req,
    ssfl_rsp_if.source o_rsp,
    ssfl_cfg_if.sink   i_cfg
);

    ssfl_pkg::t_cmd cmd;
    ssfl_pkg::t_sts sts;

    assign i_req.ready = cmd.in_ready;
    assign i_cfg.ready = 1'b1;

    ssfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_op    (i_req.op),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ssfl_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_req_valid      (i_req.valid),
        .i_req_op         (i_req.op),
        .i_free_address   (i_req.free_address),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_object_address (o_rsp.object_address),
        .o_status         (o_rsp.status),
        .o_in_use_count   (o_rsp.in_use_count),
        .o_occupancy      (o_rsp.occupancy)
    );

endmodule

`default_nettype wire

### rtl/ssfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ssfl_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/ssfl_ctrl.sv
// Sequencing state machine: clearing pass, allocate and free sequences, result hand-off.
// Depends on ssfl_pkg for the state type and command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module ssfl_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    input  wire logic           i_req_op,
    input  wire ssfl_pkg::t_sts i_sts,
    output ssfl_pkg::t_cmd      o_cmd
);

    ssfl_pkg::t_state r_state;
    ssfl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssfl_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssfl_pkg::S_CLEAR: begin
                if (i_sts.clr_last) n_state = ssfl_pkg::S_IDLE;
            end
            ssfl_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_state = (i_req_op == ssfl_pkg::OP_FREE) ? ssfl_pkg::S_FREE_CHK
                                                              : ssfl_pkg::S_ALLOC_RD;
                end
            end
            ssfl_pkg::S_ALLOC_RD: begin
                n_state = i_sts.head_oor ? ssfl_pkg::S_DONE : ssfl_pkg::S_ALLOC_WAIT;
            end
            ssfl_pkg::S_ALLOC_WAIT: n_state = ssfl_pkg::S_DONE;
            ssfl_pkg::S_FREE_CHK:   n_state = ssfl_pkg::S_FREE_RNG;
            ssfl_pkg::S_FREE_RNG: begin
                n_state = i_sts.rng_fail ? ssfl_pkg::S_DONE : ssfl_pkg::S_FREE_DIV;
            end
            ssfl_pkg::S_FREE_DIV: begin
                if (i_sts.div_last) n_state = ssfl_pkg::S_FREE_END;
            end
            ssfl_pkg::S_FREE_END:   n_state = ssfl_pkg::S_DONE;
            ssfl_pkg::S_DONE: begin
                if (i_sts.out_free) n_state = ssfl_pkg::S_IDLE;
            end
            default:                n_state = ssfl_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ssfl_pkg::S_CLEAR:      o_cmd.clr_wr     = 1'b1;
            ssfl_pkg::S_IDLE:       o_cmd.in_ready   = 1'b1;
            ssfl_pkg::S_ALLOC_RD:   o_cmd.alloc_rd   = 1'b1;
            ssfl_pkg::S_ALLOC_WAIT: o_cmd.alloc_link = 1'b1;
            ssfl_pkg::S_FREE_CHK:   o_cmd.free_sub   = 1'b1;
            ssfl_pkg::S_FREE_RNG:   o_cmd.free_rng   = 1'b1;
            ssfl_pkg::S_FREE_DIV:   o_cmd.div_step   = 1'b1;
            ssfl_pkg::S_FREE_END:   o_cmd.free_end   = 1'b1;
            ssfl_pkg::S_DONE:       o_cmd.commit     = 1'b1;
            default:                o_cmd            = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/ssfl_dp.sv
// Datapath: configuration registers, free-list head and link RAM, address multiply,
// restoring divider for slot index recovery, and the result register.
// Depends on ssfl_pkg and ssfl_ram.
`timescale 1ns / 1ps
`default_nettype none

module ssfl_dp #(
    parameter int SLOTS = 512
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ssfl_pkg::t_cmd                  i_cmd,
    output ssfl_pkg::t_sts                       o_sts,
    input  wire logic                            i_req_valid,
    input  wire logic                            i_req_op,
    input  wire logic [ssfl_pkg::ADDR_W-1:0]     i_free_address,
    input  wire logic                            i_cfg_valid,
    input  wire logic [ssfl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ssfl_pkg::ADDR_W-1:0]     i_cfg_data,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic      [ssfl_pkg::ADDR_W-1:0]     o_object_address,
    output logic      [ssfl_pkg::STAT_W-1:0]     o_status,
    output logic      [ssfl_pkg::CNT_W-1:0]      o_in_use_count,
    output logic      [ssfl_pkg::OCC_W-1:0]      o_occupancy
);

    localparam int AW = $clog2(SLOTS);
    localparam int W  = $clog2(SLOTS + 1);
    localparam int SW = (W > 1) ? $clog2(W) : 1;
    localparam int CW = (W > ssfl_pkg::CNT_W) ? W : ssfl_pkg::CNT_W;
    localparam int PW = W + ssfl_pkg::SIZE_W;

    logic [ssfl_pkg::ADDR_W-1:0] r_base;
    logic [ssfl_pkg::SIZE_W-1:0] r_size;
    logic [ssfl_pkg::CNT_W-1:0]  r_count;
    logic [W-1:0]                r_head;
    logic [ssfl_pkg::CNT_W-1:0]  r_used;
    logic [AW-1:0]               r_clr;
    logic                        r_out_valid;

    logic                        r_op;
    logic [ssfl_pkg::ADDR_W-1:0] r_faddr;
    logic [PW-1:0]               r_prod;
    logic [ssfl_pkg::ADDR_W-1:0] r_addr;
    logic [W-1:0]                r_link;
    logic [ssfl_pkg::ADDR_W-1:0] r_off;
    logic                        r_ge;
    logic [ssfl_pkg::STAT_W-1:0] r_status;
    logic [PW-1:0]               r_rem;
    logic [PW-1:0]               r_dvs;
    logic [W-1:0]                r_quo;
    logic [SW-1:0]               r_step;
    logic [ssfl_pkg::ADDR_W-1:0] r_o_addr;
    logic [ssfl_pkg::STAT_W-1:0] r_o_status;
    logic [ssfl_pkg::CNT_W-1:0]  r_o_used;
    logic [ssfl_pkg::OCC_W-1:0]  r_o_occ;

    logic [CW-1:0]               n_ext;
    logic [W-1:0]                eff_n;
    logic [W-1:0]                mul_a;
    logic [PW-1:0]               product;
    logic                        rem_ge;
    logic                        out_free;
    logic                        commit;
    logic                        ok;
    logic                        free_wr;
    logic [ssfl_pkg::CNT_W-1:0]  n_used;
    logic [W-1:0]                n_head;
    logic [ssfl_pkg::OCC_W-1:0]  n_occ;
    logic                        mem_wr_en;
    logic [AW-1:0]               mem_wr_addr;
    logic [W-1:0]                mem_wr_data;
    logic [W-1:0]                mem_rd_data;

    always_comb begin
        n_ext = (CW'(r_count) > CW'(SLOTS)) ? CW'(SLOTS) : CW'(r_count);
        eff_n = W'(n_ext);
    end

    assign mul_a   = i_cmd.alloc_rd ? r_head : eff_n;
    assign product = PW'(mul_a) * PW'(r_size);
    assign rem_ge  = (r_rem >= r_dvs);

    assign out_free = !r_out_valid || i_out_ready;
    assign commit   = i_cmd.commit && out_free;
    assign ok       = (r_status == ssfl_pkg::ST_OK);
    assign free_wr  = commit && ok && (r_op == ssfl_pkg::OP_FREE);

    always_comb begin
        o_sts.clr_last = (r_clr == AW'(SLOTS - 1));
        o_sts.head_oor = (CW'(r_head) >= n_ext);
        o_sts.rng_fail = !(r_ge && (r_off < ssfl_pkg::ADDR_W'(r_prod)));
        o_sts.div_last = (r_step == '0);
        o_sts.out_free = out_free;
    end

    always_comb begin
        n_used = r_used;
        n_head = r_head;
        if (ok && (r_op == ssfl_pkg::OP_ALLOC)) begin
            n_head = r_link;
            if (r_used != ssfl_pkg::COUNT_MAX) n_used = r_used + 1'b1;
        end else if (ok) begin
            n_head = r_quo;
            n_used = r_used - 1'b1;
        end
        priority if (n_used == '0) begin
            n_occ = ssfl_pkg::OCC_EMPTY;
        end else if (CW'(n_used) >= n_ext) begin
            n_occ = ssfl_pkg::OCC_FULL;
        end else begin
            n_occ = ssfl_pkg::OCC_PARTIAL;
        end
    end

    assign mem_wr_en   = i_cmd.clr_wr || free_wr;
    assign mem_wr_addr = i_cmd.clr_wr ? r_clr : r_quo[AW-1:0];
    assign mem_wr_data = i_cmd.clr_wr ? (W'(r_clr) + W'(1)) : r_head;

    ssfl_ram #(
        .WIDTH (W),
        .DEPTH (SLOTS)
    ) u_links (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (i_cmd.alloc_rd),
        .i_rd_addr (r_head[AW-1:0]),
        .o_rd_data (mem_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= ssfl_pkg::BASE_RST;
            r_size      <= ssfl_pkg::SIZE_RST;
            r_count     <= ssfl_pkg::COUNT_RST;
            r_head      <= '0;
            r_used      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    ssfl_pkg::CFG_BASE:  r_base  <= i_cfg_data;
                    ssfl_pkg::CFG_SIZE:  r_size  <= i_cfg_data[ssfl_pkg::SIZE_W-1:0];
                    ssfl_pkg::CFG_COUNT: r_count <= i_cfg_data[ssfl_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clr_wr) r_clr <= r_clr + 1'b1;
            if (commit) begin
                r_head      <= n_head;
                r_used      <= n_used;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_ready && i_req_valid) begin
            r_op    <= i_req_op;
            r_faddr <= i_free_address;
        end
        if (i_cmd.alloc_rd) begin
            r_prod   <= product;
            r_addr   <= '0;
            r_status <= o_sts.head_oor ? ssfl_pkg::ST_FULL : ssfl_pkg::ST_OK;
        end
        if (i_cmd.alloc_link) begin
            r_link <= mem_rd_data;
            r_addr <= r_base + ssfl_pkg::ADDR_W'(r_prod);
        end
        if (i_cmd.free_sub) begin
            r_prod <= product;
            r_addr <= '0;
            r_off  <= r_faddr - r_base;
            r_ge   <= (r_faddr >= r_base);
        end
        if (i_cmd.free_rng) begin
            r_status <= o_sts.rng_fail ? ssfl_pkg::ST_NOT_IN_SLAB : ssfl_pkg::ST_OK;
            r_rem    <= PW'(r_off);
            r_dvs    <= PW'(r_size) << (W - 1);
            r_quo    <= '0;
            r_step   <= SW'(W - 1);
        end
        if (i_cmd.div_step) begin
            if (rem_ge) r_rem <= r_rem - r_dvs;
            r_dvs  <= r_dvs >> 1;
            r_quo  <= {r_quo[W-2:0], rem_ge};
            r_step <= r_step - 1'b1;
        end
        if (i_cmd.free_end) begin
            priority if (r_rem != '0) begin
                r_status <= ssfl_pkg::ST_NOT_IN_SLAB;
            end else if (r_used == '0) begin
                r_status <= ssfl_pkg::ST_NOTHING_USED;
            end else begin
                r_status <= ssfl_pkg::ST_OK;
            end
        end
        if (commit) begin
            r_o_addr   <= r_addr;
            r_o_status <= r_status;
            r_o_used   <= n_used;
            r_o_occ    <= n_occ;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_object_address = r_o_addr;
    assign o_status         = r_o_status;
    assign o_in_use_count   = r_o_used;
    assign o_occupancy      = r_o_occ;

endmodule

`default_nettype wire

### rtl/ssfl_chk.sv
// Port-level checker for the slab slot free-list allocator, bound to the top level.
// Depends on ssfl_pkg for status and occupancy codes.
`timescale 1ns / 1ps
`default_nettype none

module ssfl_chk (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_req_valid,
    input wire logic                        i_req_ready,
    input wire logic                        i_rsp_valid,
    input wire logic                        i_rsp_ready,
    input wire logic [ssfl_pkg::ADDR_W-1:0] i_object_address,
    input wire logic [ssfl_pkg::STAT_W-1:0] i_status,
    input wire logic [ssfl_pkg::CNT_W-1:0]  i_in_use_count,
    input wire logic [ssfl_pkg::OCC_W-1:0]  i_occupancy
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_object_address)
            && $stable(i_status) && $stable(i_in_use_count) && $stable(i_occupancy))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while another is in flight");

    a_err_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status != ssfl_pkg::ST_OK) |-> i_object_address == '0)
        else $error("failed request returned an address");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_in_use_count == '0) |-> i_occupancy == ssfl_pkg::OCC_EMPTY)
        else $error("zero count not reported empty");

    a_nothing_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status == ssfl_pkg::ST_NOTHING_USED) |-> i_in_use_count == '0)
        else $error("nothing-in-use error with slots allocated");

endmodule

bind slab_slot_free_list_allocator ssfl_chk u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_object_address (o_rsp.object_address),
    .i_status         (o_rsp.status),
    .i_in_use_count   (o_rsp.in_use_count),
    .i_occupancy      (o_rsp.occupancy)
);

`default_nettype wire
